FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the MIDI UART port parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Concurrent assertion that is switched off while the reset is asserted.
`define ASSERT_AR(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Concurrent assertion that is checked at every clock edge, reset included.
`define ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_AR(lbl, clk, rst_n, prop)
`define ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: rtl/mup_pkg.sv
// Package with the constants and types of the MIDI UART port parser.
`timescale 1ns / 1ps
package mup_pkg;

  localparam logic [7:0]  SYSEX_START   = 8'hF0;
  localparam logic [7:0]  SYSEX_END     = 8'hF7;
  localparam logic [7:0]  CMD_UART      = 8'h3F;
  localparam logic [7:0]  CMD_RESET     = 8'hFF;
  localparam logic [7:0]  ACK_BYTE      = 8'hFE;
  localparam logic [7:0]  STATUS_IDLE   = 8'h80;
  localparam logic [15:0] LENGTHS_RESET = 16'h7AFF;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam logic PORT_DATA  = 1'b0;
  localparam logic PORT_CMD   = 1'b1;

  typedef struct packed {
    logic       func;
    logic       port;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        short_valid;
    logic [23:0] short_message;
    logic        sysex_valid;
    logic [7:0]  sysex_byte;
    logic        sysex_last;
  } result_t;

endpackage

FILE: rtl/mup_in_if.sv
// Interface of the bus access channel into the parser.
`timescale 1ns / 1ps
interface mup_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       port;
  logic [7:0] data;

  modport source (output valid, output func, output port, output data, input ready);
  modport sink   (input valid, input func, input port, input data, output ready);
endinterface

FILE: rtl/mup_out_if.sv
// Interface of the result channel out of the parser.
`timescale 1ns / 1ps
interface mup_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        short_valid;
  logic [23:0] short_message;
  logic        sysex_valid;
  logic [7:0]  sysex_byte;
  logic        sysex_last;

  modport source (output valid, output read_data, output short_valid, output short_message,
                  output sysex_valid, output sysex_byte, output sysex_last, input ready);
  modport sink   (input valid, input read_data, input short_valid, input short_message,
                  input sysex_valid, input sysex_byte, input sysex_last, output ready);
endinterface

FILE: rtl/midi_uart_port_parser.sv
// Top level of the two-port MIDI UART parser with its result register.
//
//   channel   direction  handshake            word
//   req_i     in         valid/ready          func, port, data
//   rsp_o     out        valid/ready          read_data, short and sysex fields
//   cfg       in         cfg_we_i, no stall   cfg_wdata_i (message lengths)
//
// Each accepted word gives one result word: it is held in the input register,
// then passes through the framing logic into the result register.
// A new word is accepted every cycle while the result side keeps up.
// A stall on rsp_o holds the result register and then the input register.
// Reset clears all port and framing state and loads the default length table.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module midi_uart_port_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  mup_in_if.sink      req_i,
  mup_out_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0]      lengths_q;
  logic             in_vld;
  mup_pkg::item_t   in_item;
  logic             adv;
  mup_pkg::result_t res;
  logic             out_vld_q, out_vld_d;
  mup_pkg::result_t res_q;

  assign adv = in_vld && (!out_vld_q || rsp_o.ready);

  mup_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .adv_i  (adv),
    .vld_o  (in_vld),
    .item_o (in_item)
  );

  mup_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .item_i    (in_item),
    .lengths_i (lengths_q),
    .res_o     (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      lengths_q <= mup_pkg::LENGTHS_RESET;
    end else begin
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        lengths_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.read_data     = res_q.read_data;
  assign rsp_o.short_valid   = res_q.short_valid;
  assign rsp_o.short_message = res_q.short_message;
  assign rsp_o.sysex_valid   = res_q.sysex_valid;
  assign rsp_o.sysex_byte    = res_q.sysex_byte;
  assign rsp_o.sysex_last    = res_q.sysex_last;

  `ASSERT_AR(a_one_message_kind, clk_i, rst_ni, out_vld_q |-> !(res_q.short_valid && res_q.sysex_valid))

endmodule

FILE: rtl/mup_in_reg.sv
// Input register stage that captures one bus access word per cycle while it is empty or advancing.
`timescale 1ns / 1ps
module mup_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  mup_in_if.sink         req_i,
  input  logic           adv_i,
  output logic           vld_o,
  output mup_pkg::item_t item_o
);

  logic           vld_q, vld_d;
  mup_pkg::item_t item_q, item_d;
  logic           take;

  assign req_i.ready = !vld_q || adv_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (take) begin
      vld_d       = 1'b1;
      item_d.func = req_i.func;
      item_d.port = req_i.port;
      item_d.data = req_i.data;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

FILE: rtl/mup_engine.sv
// Port state, message framing and result forming for one bus access word.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mup_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mup_pkg::item_t   item_i,
  input  logic [15:0]      lengths_i,
  output mup_pkg::result_t res_o
);

  logic            busy_q, busy_d;
  logic            armed_q, armed_d;
  logic [7:0]      running_q, running_d;
  logic [1:0]      fill_q, fill_d;
  logic [2:0][7:0] buf_q, buf_d;

  logic [1:0] pos;
  logic [1:0] nfill;
  logic [1:0] len;

  always_comb begin
    busy_d    = busy_q;
    armed_d   = armed_q;
    running_d = running_q;
    fill_d    = fill_q;
    buf_d     = buf_q;
    res_o     = '0;
    pos       = fill_q;
    nfill     = fill_q;
    len       = 2'd0;
    if (item_i.func == mup_pkg::FUNC_READ) begin
      if (item_i.port == mup_pkg::PORT_CMD) begin
        busy_d          = 1'b1;
        armed_d         = 1'b0;
        res_o.read_data = mup_pkg::ACK_BYTE;
      end else begin
        res_o.read_data = {busy_q, 7'd0};
      end
    end else if (item_i.port == mup_pkg::PORT_CMD) begin
      if (item_i.data == mup_pkg::CMD_UART) begin
        busy_d = 1'b0;
      end
      if (item_i.data == mup_pkg::CMD_RESET) begin
        armed_d = 1'b1;
        fill_d  = 2'd0;
        busy_d  = 1'b0;
      end
    end else if (!armed_q) begin
      if (running_q == mup_pkg::SYSEX_START) begin
        res_o.sysex_valid = 1'b1;
        res_o.sysex_byte  = item_i.data;
        if (item_i.data == mup_pkg::SYSEX_END) begin
          res_o.sysex_last = 1'b1;
          running_d        = mup_pkg::STATUS_IDLE;
          buf_d[0]         = mup_pkg::STATUS_IDLE;
          fill_d           = 2'd0;
        end
      end else begin
        // A data byte with no message open reuses the running status.
        if (!item_i.data[7] && fill_q == 2'd0) begin
          buf_d[0] = running_q;
          pos      = 2'd1;
        end
        case (pos)
          2'd0:    buf_d[0] = item_i.data;
          2'd1:    buf_d[1] = item_i.data;
          2'd2:    buf_d[2] = item_i.data;
          default: buf_d[2] = item_i.data;
        endcase
        nfill     = pos + 2'd1;
        running_d = buf_d[0];
        len       = lengths_i[{buf_d[0][6:4], 1'b0} +: 2];
        if (buf_d[0] == mup_pkg::SYSEX_START) begin
          res_o.sysex_valid = 1'b1;
          res_o.sysex_byte  = mup_pkg::SYSEX_START;
          fill_d            = nfill;
        end else if (nfill >= len) begin
          res_o.short_valid   = 1'b1;
          res_o.short_message = {buf_d[2], buf_d[1], buf_d[0]};
          fill_d              = 2'd0;
        end else begin
          fill_d = nfill;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      armed_q   <= 1'b0;
      running_q <= mup_pkg::STATUS_IDLE;
      fill_q    <= 2'd0;
      buf_q     <= '0;
    end else if (step_i) begin
      busy_q    <= busy_d;
      armed_q   <= armed_d;
      running_q <= running_d;
      fill_q    <= fill_d;
      buf_q     <= buf_d;
    end
  end

  `ASSERT_NR(a_fill_range, clk_i, fill_q != 2'd3)
  `ASSERT_AR(a_running_is_status, clk_i, rst_ni, running_q[7])
  `ASSERT_AR(a_armed_drops_data, clk_i, rst_ni, step_i && armed_q && item_i.func && !item_i.port |=> $stable(fill_q) && $stable(running_q) && $stable(buf_q))

endmodule

FILE: dv/midi_uart_port_parser_check.sv
// Checker that predicts and compares every result word of the MIDI UART port parser.
`timescale 1ns / 1ps
module mup_result_check
  import mup_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mup_in_if           req_if,
  mup_out_if          rsp_if,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          errors_o,
  output int          pending_o
);

  localparam logic [7:0] BUSY_BIT = 8'h80;

  logic [15:0] lengths_q;
  logic [7:0]  status_q;
  logic        reset_armed_q;
  logic [7:0]  running_q;
  logic [1:0]  fill_q;
  logic [7:0]  msg_q [3];
  result_t     expected_words [$];
  int          error_cnt;

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
             want);
    error_cnt++;
  endtask

  task automatic check_field(input string what, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic void queue_expected(input result_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  // Applies one bus access to the predicted port state and returns its result word.
  function automatic result_t parse_access(logic func, logic port, logic [7:0] d);
    result_t    r;
    logic [2:0] slot;
    logic [1:0] span;
    r = '0;
    if (func == FUNC_READ) begin
      if (port == PORT_CMD) begin
        status_q      = status_q | BUSY_BIT;
        reset_armed_q = 1'b0;
        r.read_data   = ACK_BYTE;
      end else begin
        r.read_data = status_q;
      end
    end else if (port == PORT_CMD) begin
      if (d == CMD_UART) begin
        status_q = status_q & ~BUSY_BIT;
      end
      if (d == CMD_RESET) begin
        reset_armed_q = 1'b1;
        fill_q        = 2'd0;
        status_q      = status_q & ~BUSY_BIT;
      end
    end else if (!reset_armed_q) begin
      if (running_q == SYSEX_START) begin
        r.sysex_valid = 1'b1;
        r.sysex_byte  = d;
        if (d == SYSEX_END) begin
          r.sysex_last = 1'b1;
          running_q    = STATUS_IDLE;
          msg_q[0]     = STATUS_IDLE;
          fill_q       = 2'd0;
        end
      end else begin
        if (!d[7] && fill_q == 2'd0) begin
          msg_q[0] = running_q;
          fill_q   = 2'd1;
        end
        msg_q[fill_q] = d;
        fill_q        = fill_q + 2'd1;
        running_q     = msg_q[0];
        if (msg_q[0] == SYSEX_START) begin
          r.sysex_valid = 1'b1;
          r.sysex_byte  = SYSEX_START;
        end else begin
          slot = 3'(msg_q[0][7:4] - 4'd8);
          span = lengths_q[2 * slot +: 2];
          if (fill_q >= span || fill_q == 2'd0) begin
            r.short_valid   = 1'b1;
            r.short_message = {msg_q[2], msg_q[1], msg_q[0]};
            fill_q          = 2'd0;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      lengths_q     = LENGTHS_RESET;
      status_q      = 8'h00;
      reset_armed_q = 1'b0;
      running_q     = STATUS_IDLE;
      fill_q        = 2'd0;
      msg_q[0]      = 8'h00;
      msg_q[1]      = 8'h00;
      msg_q[2]      = 8'h00;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        lengths_q = cfg_wdata_i;
      end
      if (req_if.valid && req_if.ready) begin
        queue_expected(parse_access(req_if.func, req_if.port, req_if.data));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", 24'(rsp_if.read_data), 24'h0);
        end else begin
          want = expected_words.pop_front();
          check_field("read_data", 24'(rsp_if.read_data), 24'(want.read_data));
          check_field("short_valid", 24'(rsp_if.short_valid), 24'(want.short_valid));
          check_field("short_message", rsp_if.short_message, want.short_message);
          check_field("sysex_valid", 24'(rsp_if.sysex_valid), 24'(want.sysex_valid));
          check_field("sysex_byte", 24'(rsp_if.sysex_byte), 24'(want.sysex_byte));
          check_field("sysex_last", 24'(rsp_if.sysex_last), 24'(want.sysex_last));
        end
      end
    end
    pending_o <= expected_words.size();
    errors_o  <= error_cnt;
  end

endmodule

FILE: dv/midi_uart_port_parser_tb.sv
// Top of the MIDI UART port parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module midi_uart_port_parser_tb;
  import mup_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  int          errors;
  int          pending;
  int          words_sent;
  bit          offering;
  bit          sender_calm;
  bit          receiver_calm;
  bit          hold_off_req;

  mup_in_if  req_if ();
  mup_out_if rsp_if ();

  midi_uart_port_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  mup_result_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_if      (req_if),
    .rsp_if      (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int hold;
    int g;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (receiver_calm) begin
        rsp_if.ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          hold = g - 1;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_word(input logic f, input logic p, input logic [7:0] d);
    int   gap;
    logic took;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      if (offering) begin
        req_if.valid <= 1'b0;
      end
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.port  <= p;
    req_if.data  <= d;
    offering = 1'b1;
    do begin
      @(negedge clk_i);
      took = req_if.ready;
      @(posedge clk_i);
    end while (!took);
    words_sent++;
  endtask

  task automatic wait_idle();
    if (offering) begin
      req_if.valid <= 1'b0;
    end
    offering = 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_lengths(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random phrase: mostly channel messages and sysex blocks, some port traffic and noise.
  task automatic send_phrase();
    int         kind;
    int         n;
    logic [7:0] st;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      if ($urandom_range(0, 3) != 0) begin
        send_word(FUNC_WRITE, PORT_DATA, st);
      end
      n = $urandom_range(0, 2);
      repeat (n) send_word(FUNC_WRITE, PORT_DATA, {1'b0, 7'($urandom)});
    end else if (kind < 65) begin
      send_word(FUNC_WRITE, PORT_DATA, SYSEX_START);
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) begin
          send_word(FUNC_WRITE, PORT_DATA, 8'($urandom));
        end else begin
          send_word(FUNC_WRITE, PORT_DATA, {1'b0, 7'($urandom)});
        end
      end
      send_word(FUNC_WRITE, PORT_DATA, SYSEX_END);
    end else if (kind < 80) begin
      send_word(FUNC_READ, 1'($urandom), 8'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        send_word(FUNC_WRITE, PORT_CMD, CMD_UART);
      end
    end else if (kind < 88) begin
      send_word(FUNC_WRITE, PORT_CMD, CMD_RESET);
      n = $urandom_range(0, 2);
      repeat (n) send_word(FUNC_WRITE, PORT_DATA, 8'($urandom));
      send_word(FUNC_READ, PORT_CMD, 8'($urandom));
    end else begin
      send_word(1'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_random(input int count);
    int start;
    start = words_sent;
    while (words_sent - start < count) begin
      send_phrase();
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.func   = FUNC_READ;
    req_if.port   = PORT_DATA;
    req_if.data   = 8'h00;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 16'h0000;
    words_sent    = 0;
    offering      = 1'b0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    hold_off_req  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Port commands, reads, and data dropped while reset is armed.
    send_word(FUNC_READ, PORT_CMD, 8'h00);
    send_word(FUNC_READ, PORT_DATA, 8'hFF);
    send_word(FUNC_WRITE, PORT_CMD, CMD_UART);
    send_word(FUNC_WRITE, PORT_CMD, 8'h00);
    send_word(FUNC_WRITE, PORT_CMD, CMD_RESET);
    send_word(FUNC_WRITE, PORT_DATA, 8'h90);
    send_word(FUNC_READ, PORT_CMD, 8'h00);
    send_word(FUNC_READ, PORT_DATA, 8'h00);
    // Note on, running status, and a status byte in mid-message.
    send_word(FUNC_WRITE, PORT_DATA, 8'h90);
    send_word(FUNC_WRITE, PORT_DATA, 8'h3C);
    send_word(FUNC_WRITE, PORT_DATA, 8'h7F);
    send_word(FUNC_WRITE, PORT_DATA, 8'h00);
    send_word(FUNC_WRITE, PORT_DATA, 8'h80);
    // Sysex with a status byte inside and a reset in the middle of it.
    send_word(FUNC_WRITE, PORT_DATA, SYSEX_START);
    send_word(FUNC_WRITE, PORT_DATA, 8'h01);
    send_word(FUNC_WRITE, PORT_CMD, CMD_RESET);
    send_word(FUNC_WRITE, PORT_DATA, 8'h11);
    send_word(FUNC_READ, PORT_CMD, 8'h00);
    send_word(FUNC_WRITE, PORT_DATA, 8'h99);
    send_word(FUNC_WRITE, PORT_DATA, SYSEX_END);
    send_word(FUNC_WRITE, PORT_DATA, 8'hFF);
    send_word(FUNC_WRITE, PORT_DATA, 8'h7F);

    write_lengths(16'h0000);
    run_random(100);

    // Hold the result side off while the sender streams without gaps.
    wait_idle();
    sender_calm  = 1'b1;
    hold_off_req = 1'b1;
    run_random(30);
    wait_idle();
    sender_calm = 1'b0;

    write_lengths(16'hFFFF);
    run_random(100);

    write_lengths(16'($urandom));
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    run_random(60);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;

    write_lengths(16'($urandom));
    run_random(100);

    write_lengths(LENGTHS_RESET);
    run_random(80);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mup_pkg.sv
rtl/mup_in_if.sv
rtl/mup_out_if.sv
rtl/mup_in_reg.sv
rtl/mup_engine.sv
rtl/midi_uart_port_parser.sv
dv/midi_uart_port_parser_check.sv
dv/midi_uart_port_parser_tb.sv
